FILE: sv/gbk_ss_pkg.sv
// Shared codes, constants, types and helpers for the GBK sentence splitter.
package gbk_ss_pkg;

   // Input action codes
   localparam logic [1:0] ACT_TEXT      = 2'd0;
   localparam logic [1:0] ACT_LINE_END  = 2'd1;
   localparam logic [1:0] ACT_INPUT_END = 2'd2;

   // Result kind codes
   localparam logic KIND_TEXT  = 1'b0;
   localparam logic KIND_BREAK = 1'b1;

   // Byte values that matter to the character and punctuation logic
   localparam logic [7:0] SINGLE_LIMIT = 8'd128;
   localparam logic [7:0] LEAD_A1      = 8'd161;
   localparam logic [7:0] LEAD_A3      = 8'd163;
   localparam logic [7:0] TRAIL_DASH   = 8'd170;
   localparam logic [7:0] TRAIL_A1     = 8'd161;
   localparam logic [7:0] TRAIL_A3     = 8'd163;
   localparam logic [7:0] TRAIL_AC     = 8'd172;
   localparam logic [7:0] TRAIL_B0     = 8'd176;
   localparam logic [7:0] TRAIL_B1     = 8'd177;
   localparam logic [7:0] TRAIL_BA     = 8'd186;
   localparam logic [7:0] TRAIL_BB     = 8'd187;
   localparam logic [7:0] TRAIL_BF     = 8'd191;

   // Dash run counter saturates here (two or more dashes)
   localparam logic [1:0] DASH_RUN_MIN = 2'd2;

   // Most results one transaction can cause
   localparam int RES_MAX = 4;
   localparam int RES_CNT_W = $clog2(RES_MAX + 1);
   localparam int RES_IDX_W = $clog2(RES_MAX);

   typedef struct packed {
      logic       kind;
      logic [7:0] data;
   } res_entry_type;

   typedef struct packed {
      logic [RES_CNT_W-1:0]      count;
      res_entry_type [RES_MAX-1:0] ent;
   } res_list_type;

   typedef struct packed {
      logic [7:0] held_lead;
      logic       lead_waiting;
      logic [1:0] dash_run;
   } split_state_type;

   // Double-byte punctuation codes that end a sentence
   function automatic logic is_punct(logic [7:0] lead, logic [7:0] trail);
      logic hit;
      hit = 1'b0;
      if (lead == LEAD_A3) begin
         hit = (trail == TRAIL_A1) || (trail == TRAIL_BB) || (trail == TRAIL_AC) ||
               (trail == TRAIL_BF) || (trail == TRAIL_BA);
      end else if (lead == LEAD_A1) begin
         hit = (trail == TRAIL_A3) || (trail == TRAIL_B0) || (trail == TRAIL_B1);
      end
      return hit;
   endfunction

   // Append one result to a list
   function automatic res_list_type push(res_list_type lst, logic kind, logic [7:0] data);
      res_list_type r;
      r = lst;
      r.ent[lst.count[RES_IDX_W-1:0]] = '{kind: kind, data: data};
      r.count = lst.count + RES_CNT_W'(1);
      return r;
   endfunction

endpackage

FILE: sv/gbk_ss_decode.sv
// Combinational decode: one registered transaction to its result list and next state.
module gbk_ss_decode (
   input  logic [1:0]                  action,
   input  logic [7:0]                  byte_value,
   input  gbk_ss_pkg::split_state_type cur_state,
   output gbk_ss_pkg::res_list_type    res_list,
   output gbk_ss_pkg::split_state_type nxt_state
);
   import gbk_ss_pkg::*;

   always_comb begin
      res_list  = '0;
      nxt_state = cur_state;
      unique case (action)
         ACT_TEXT: begin
            if (cur_state.lead_waiting) begin
               // Pair the held lead with this trail
               nxt_state.lead_waiting = 1'b0;
               nxt_state.held_lead    = '0;
               if ((cur_state.held_lead == LEAD_A1) && (byte_value == TRAIL_DASH)) begin
                  res_list = push(res_list, KIND_TEXT, cur_state.held_lead);
                  res_list = push(res_list, KIND_TEXT, byte_value);
                  if (cur_state.dash_run < DASH_RUN_MIN) begin
                     nxt_state.dash_run = cur_state.dash_run + 2'd1;
                  end
               end else begin
                  if (cur_state.dash_run >= DASH_RUN_MIN) begin
                     res_list = push(res_list, KIND_BREAK, 8'd0);
                  end
                  nxt_state.dash_run = '0;
                  res_list = push(res_list, KIND_TEXT, cur_state.held_lead);
                  res_list = push(res_list, KIND_TEXT, byte_value);
                  if (is_punct(cur_state.held_lead, byte_value)) begin
                     res_list = push(res_list, KIND_BREAK, 8'd0);
                  end
               end
            end else if (byte_value < SINGLE_LIMIT) begin
               // Single-byte character ends any dash run
               if (cur_state.dash_run >= DASH_RUN_MIN) begin
                  res_list = push(res_list, KIND_BREAK, 8'd0);
               end
               nxt_state.dash_run = '0;
               res_list = push(res_list, KIND_TEXT, byte_value);
            end else begin
               // Hold the lead byte until its trail arrives
               nxt_state.held_lead    = byte_value;
               nxt_state.lead_waiting = 1'b1;
            end
         end
         ACT_LINE_END, ACT_INPUT_END: begin
            // Flush the dash break and any lone lead byte
            if (cur_state.dash_run >= DASH_RUN_MIN) begin
               res_list = push(res_list, KIND_BREAK, 8'd0);
            end
            if (cur_state.lead_waiting) begin
               res_list = push(res_list, KIND_TEXT, cur_state.held_lead);
            end
            nxt_state = '0;
            if (action == ACT_INPUT_END) begin
               res_list = push(res_list, KIND_BREAK, 8'd0);
            end
         end
         default: begin
            // Unused action code: no results, state kept
         end
      endcase
   end

endmodule

FILE: sv/gbk_ss_out_buf.sv
// Result register: holds one transaction's results; sends one per cycle unless stalled.
module gbk_ss_out_buf (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  gbk_ss_pkg::res_list_type res_list,
   output logic                     free,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_kind,
   output logic [7:0]               rsp_out_byte,
   output logic                     rsp_last
);
   import gbk_ss_pkg::*;

   res_entry_type [RES_MAX-1:0] ent_ff, ent_in;
   logic [RES_CNT_W-1:0]        rem_ff, rem_in;
   logic                        take;

   assign rsp_valid    = (rem_ff != '0);
   assign take         = rsp_valid && rsp_ready;
   assign rsp_last     = (rem_ff == RES_CNT_W'(1));
   assign rsp_kind     = ent_ff[0].kind;
   assign rsp_out_byte = ent_ff[0].data;
   // Empty, or the final entry leaves this cycle
   assign free         = !rsp_valid || (rsp_last && rsp_ready);

   // Load a new list, or advance the current one
   always_comb begin
      ent_in = ent_ff;
      rem_in = rem_ff;
      if (load) begin
         ent_in = res_list.ent;
         rem_in = res_list.count;
      end else if (take) begin
         for (int i = 0; i < RES_MAX - 1; i++) begin
            ent_in[i] = ent_ff[i+1];
         end
         rem_in = rem_ff - RES_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
      end else begin
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

endmodule

FILE: sv/gbk_sentence_splitter.sv
// Top level of the GBK sentence splitter: input register, decode, result register.
//
//   channel | ports                                       | direction
//   req     | req_valid req_ready req_action req_byte_value | in
//   rsp     | rsp_valid rsp_ready rsp_kind rsp_out_byte rsp_last | out
//
// A transaction is registered in the input stage, decoded combinationally
// into up to four results and loaded into the result register, which puts
// the first result on rsp.
// The result register sends one result per cycle while rsp_ready is high.
// The registered transaction moves on when the result register is empty or
// its last result leaves, and a new one is accepted in that same cycle.
// Synchronous active-high reset clears the input stage, result count and
// character/dash state. A stall on rsp holds both stages.
module gbk_sentence_splitter (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_action,
   input  logic [7:0] req_byte_value,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_kind,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last
);
   import gbk_ss_pkg::*;

   logic            in_valid_ff, in_valid_in;
   logic [1:0]      in_action_ff;
   logic [7:0]      in_byte_ff;
   split_state_type state_ff, state_in, state_nxt;
   res_list_type    res_list;
   logic            buf_free;
   logic            advance;

   // Move the registered transaction into the result register
   assign advance   = in_valid_ff && buf_free;
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      state_in = advance ? state_nxt : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff    <= state_in;
      end
   end

   // Capture the payload on acceptance
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_action_ff <= req_action;
         in_byte_ff   <= req_byte_value;
      end
   end

   gbk_ss_decode u_decode (
      .action     (in_action_ff),
      .byte_value (in_byte_ff),
      .cur_state  (state_ff),
      .res_list   (res_list),
      .nxt_state  (state_nxt)
   );

   gbk_ss_out_buf u_out_buf (
      .clock        (clock),
      .reset        (reset),
      .load         (advance),
      .res_list     (res_list),
      .free         (buf_free),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_kind     (rsp_kind),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

endmodule

FILE: sv/gbk_ss_checker.sv
// Port-level checker for the GBK sentence splitter, with its bind.
module gbk_ss_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [1:0] req_action,
   input logic [7:0] req_byte_value,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_kind,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last
);
   import gbk_ss_pkg::*;

   // No result straight out of reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A break carries a zero byte
   a_break_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == KIND_BREAK)) |-> (rsp_out_byte == 8'd0))
      else $error("break with nonzero byte");

   // Results of one transaction leave without gaps
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last) |=> rsp_valid)
      else $error("gap inside a transaction's results");

   // A stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_kind) && $stable(rsp_out_byte) && $stable(rsp_last)))
      else $error("stalled result changed");

   // A waiting request holds its payload
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_ready) |=>
         (req_valid && $stable(req_action) && $stable(req_byte_value)))
      else $error("waiting request changed");

endmodule

bind gbk_sentence_splitter gbk_ss_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_action     (req_action),
   .req_byte_value (req_byte_value),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_kind       (rsp_kind),
   .rsp_out_byte   (rsp_out_byte),
   .rsp_last       (rsp_last)
);

FILE: bench/testbench.sv
// Self-checking bench for the GBK sentence splitter: random byte feed, random drain stalls.
module testbench;
   import gbk_ss_pkg::*;

   // Action code that the splitter must ignore
   localparam logic [1:0] ACT_UNUSED = 2'd3;
   // Cycles with no transaction on either side before the run is given up
   localparam int STALL_LIMIT = 2000;
   // Tail wait after the last predicted result, to catch stray output
   localparam int DRAIN_TAIL = 20;
   localparam int RANDOM_ITEMS = 100;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] byte_val;
   } feed_item_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] data;
      logic       last;
   } split_result_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_action = ACT_TEXT;
   logic [7:0] req_byte_value = 8'd0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_kind;
   logic [7:0] rsp_out_byte;
   logic       rsp_last;

   feed_item_type    byte_feed_q[$];
   split_result_type split_stream_q[$];
   split_result_type step_out[$];
   feed_item_type    next_feed;
   split_result_type due;

   // Splitter state as the bench tracks it
   logic [7:0] trk_held_lead = 8'd0;
   logic       trk_lead_waiting = 1'b0;
   logic [1:0] trk_dash_run = 2'd0;

   int  feed_total = 0;
   int  real_items = 0;
   int  accepted = 0;
   int  fail_count = 0;
   int  idle_cycles = 0;
   int  feed_gap = 0;
   int  drain_stall = 0;
   bit  feed_calm = 1'b0;
   bit  drain_calm = 1'b0;
   logic req_taken = 1'b0;

   gbk_sentence_splitter uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_action    (req_action),
      .req_byte_value(req_byte_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_kind      (rsp_kind),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last      (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------
   function automatic logic ends_sentence(logic [7:0] lead, logic [7:0] trail);
      if (lead == LEAD_A3)
         return trail == TRAIL_A1 || trail == TRAIL_BB || trail == TRAIL_AC ||
                trail == TRAIL_BF || trail == TRAIL_BA;
      if (lead == LEAD_A1)
         return trail == TRAIL_A3 || trail == TRAIL_B0 || trail == TRAIL_B1;
      return 1'b0;
   endfunction

   function automatic void emit_result(logic k, logic [7:0] d);
      step_out.insert(step_out.size(), split_result_type'{kind: k, data: d, last: 1'b0});
   endfunction

   // Flush a pending dash break, then a lone lead byte
   function automatic void close_line();
      if (trk_dash_run >= DASH_RUN_MIN)
         emit_result(KIND_BREAK, 8'd0);
      trk_dash_run = 2'd0;
      if (trk_lead_waiting)
         emit_result(KIND_TEXT, trk_held_lead);
      trk_lead_waiting = 1'b0;
      trk_held_lead = 8'd0;
   endfunction

   function automatic void split_text_step(logic [1:0] act, logic [7:0] b);
      logic [7:0] lead;
      step_out.delete();
      case (act)
         ACT_TEXT: begin
            if (trk_lead_waiting) begin
               lead = trk_held_lead;
               trk_lead_waiting = 1'b0;
               trk_held_lead = 8'd0;
               if (lead == LEAD_A1 && b == TRAIL_DASH) begin
                  emit_result(KIND_TEXT, lead);
                  emit_result(KIND_TEXT, b);
                  if (trk_dash_run < DASH_RUN_MIN)
                     trk_dash_run = trk_dash_run + 2'd1;
               end else begin
                  if (trk_dash_run >= DASH_RUN_MIN)
                     emit_result(KIND_BREAK, 8'd0);
                  trk_dash_run = 2'd0;
                  emit_result(KIND_TEXT, lead);
                  emit_result(KIND_TEXT, b);
                  if (ends_sentence(lead, b))
                     emit_result(KIND_BREAK, 8'd0);
               end
            end else if (b < SINGLE_LIMIT) begin
               if (trk_dash_run >= DASH_RUN_MIN)
                  emit_result(KIND_BREAK, 8'd0);
               trk_dash_run = 2'd0;
               emit_result(KIND_TEXT, b);
            end else begin
               trk_held_lead = b;
               trk_lead_waiting = 1'b1;
            end
         end
         ACT_LINE_END: close_line();
         ACT_INPUT_END: begin
            close_line();
            emit_result(KIND_BREAK, 8'd0);
         end
         default: ;
      endcase
      // mark the final result of this transaction
      if (step_out.size() > 0)
         step_out[step_out.size() - 1].last = 1'b1;
      foreach (step_out[i])
         split_stream_q.insert(split_stream_q.size(), step_out[i]);
   endfunction

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------
   function automatic void add_feed(logic [1:0] a, logic [7:0] b);
      byte_feed_q.insert(byte_feed_q.size(), feed_item_type'{action: a, byte_val: b});
      if (a != ACT_UNUSED)
         real_items++;
   endfunction

   function automatic void add_char(logic [7:0] lead, logic [7:0] trail);
      add_feed(ACT_TEXT, lead);
      add_feed(ACT_TEXT, trail);
   endfunction

   function automatic logic [15:0] pick_punct();
      case ($urandom_range(0, 7))
         0: return {LEAD_A3, TRAIL_A1};
         1: return {LEAD_A1, TRAIL_A3};
         2: return {LEAD_A3, TRAIL_BB};
         3: return {LEAD_A3, TRAIL_AC};
         4: return {LEAD_A3, TRAIL_BF};
         5: return {LEAD_A3, TRAIL_BA};
         6: return {LEAD_A1, TRAIL_B0};
         default: return {LEAD_A1, TRAIL_B1};
      endcase
   endfunction

   // Mostly short gaps, a few long ones, none while calm
   function automatic int pick_gap(bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 65)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   initial begin
      int r;
      int n;
      logic [15:0] pair;

      // single-byte extremes, lead/trail extremes
      add_feed(ACT_TEXT, 8'd0);
      add_feed(ACT_TEXT, 8'd127);
      add_char(8'd128, 8'd255);
      add_char(8'd255, 8'd0);
      // dash run, then punctuation: four results on the last byte
      add_char(LEAD_A1, TRAIL_DASH);
      add_char(LEAD_A1, TRAIL_DASH);
      add_char(LEAD_A3, TRAIL_A1);
      // dash run, lead held at line end
      add_char(LEAD_A1, TRAIL_DASH);
      add_char(LEAD_A1, TRAIL_DASH);
      add_feed(ACT_TEXT, LEAD_A3);
      add_feed(ACT_LINE_END, 8'd255);
      // empty line, ignored action
      add_feed(ACT_LINE_END, 8'd0);
      add_feed(ACT_UNUSED, 8'd170);
      // dash run at end of input: two breaks back to back
      add_char(LEAD_A1, TRAIL_DASH);
      add_char(LEAD_A1, TRAIL_DASH);
      add_feed(ACT_INPUT_END, 8'd85);

      // random sentences with occasional noise
      while (real_items < RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 28) begin
            add_feed(ACT_TEXT, 8'($urandom_range(0, 127)));
         end else if (r < 42) begin
            pair = pick_punct();
            add_char(pair[15:8], pair[7:0]);
         end else if (r < 56) begin
            add_char(8'($urandom_range(128, 255)), 8'($urandom_range(0, 255)));
         end else if (r < 66) begin
            n = $urandom_range(1, 3);
            repeat (n) add_char(LEAD_A1, TRAIL_DASH);
         end else if (r < 74) begin
            add_feed(ACT_LINE_END, 8'($urandom_range(0, 255)));
         end else if (r < 79) begin
            add_feed(ACT_TEXT, 8'($urandom_range(128, 255)));
            add_feed(ACT_LINE_END, 8'($urandom_range(0, 255)));
         end else if (r < 83) begin
            add_feed(ACT_INPUT_END, 8'($urandom_range(0, 255)));
         end else if (r < 86) begin
            add_feed(ACT_UNUSED, 8'($urandom_range(0, 255)));
         end else begin
            add_feed(ACT_TEXT, 8'($urandom_range(0, 255)));
         end
      end
      add_feed(ACT_INPUT_END, 8'd0);
      feed_total = byte_feed_q.size();

      // hold reset, then release it
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // wait until everything is sent and every result has arrived
      while (accepted != feed_total || split_stream_q.size() != 0)
         @(negedge clock);
      repeat (DRAIN_TAIL) @(negedge clock);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // ---------------------------------------------------------------
   // Request driver
   // ---------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // hold the transaction until it is taken
      end else if (feed_gap > 0) begin
         req_valid <= 1'b0;
         feed_gap <= feed_gap - 1;
      end else if (byte_feed_q.size() > 0) begin
         next_feed = byte_feed_q.pop_front();
         req_valid <= 1'b1;
         req_action <= next_feed.action;
         req_byte_value <= next_feed.byte_val;
         feed_gap <= pick_gap(feed_calm);
         if ($urandom_range(0, 29) == 0)
            feed_calm <= !feed_calm;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // ---------------------------------------------------------------
   // Response stall driver
   // ---------------------------------------------------------------
   always @(negedge clock) begin
      if (drain_stall > 0) begin
         rsp_ready <= 1'b0;
         drain_stall <= drain_stall - 1;
      end else begin
         rsp_ready <= 1'b1;
         drain_stall <= pick_gap(drain_calm);
         if ($urandom_range(0, 39) == 0)
            drain_calm <= !drain_calm;
      end
   end

   // ---------------------------------------------------------------
   // Monitor: check results, predict from accepted requests, watchdog
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      req_taken <= req_valid && req_ready;
      if (!reset) begin
         // check a result transaction against the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (split_stream_q.size() == 0) begin
               $error("unexpected result: kind %0d, out_byte %0d, last %0d",
                      rsp_kind, rsp_out_byte, rsp_last);
               fail_count++;
            end else begin
               due = split_stream_q.pop_front();
               if (rsp_kind !== due.kind) begin
                  $error("kind: expected %0d, got %0d", due.kind, rsp_kind);
                  fail_count++;
               end
               if (rsp_out_byte !== due.data) begin
                  $error("out_byte: expected %0d, got %0d", due.data, rsp_out_byte);
                  fail_count++;
               end
               if (rsp_last !== due.last) begin
                  $error("last: expected %0d, got %0d", due.last, rsp_last);
                  fail_count++;
               end
            end
         end
         // predict the results of an accepted request transaction
         if (req_valid && req_ready) begin
            split_text_step(req_action, req_byte_value);
            accepted++;
         end
      end
      // give up when nothing moves for too long
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

endmodule

FILE: files.f
sv/gbk_ss_pkg.sv
sv/gbk_ss_decode.sv
sv/gbk_ss_out_buf.sv
sv/gbk_sentence_splitter.sv
sv/gbk_ss_checker.sv
bench/testbench.sv
